// ===== sv/iss_pkg.sv =====
// Shared types and constants for the indexed sequence store.
// Holds the request and response word layouts and the operation and status codes.
// No dependencies.
`default_nettype none

package iss_pkg;

	localparam int Depth = 16;
	localparam int CntW  = $clog2(Depth + 1);
	localparam int IdxW  = $clog2(Depth);
	localparam int DataW = 32;

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef struct packed {
		mode_t                    mode;
		logic [CntW-1:0]          position;
		logic signed [DataW-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [DataW-1:0]  read_value;
		status_t                  status;
		logic [CntW-1:0]          count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== sv/indexed_sequence_store_top.sv =====
// Indexed sequence store: top level with request register, cell row and response register.
// Depends on iss_pkg for word layouts, codes and depth.
//
// Keeps an ordered list of up to iss_pkg::Depth signed 32-bit values in a row of
// cells. Each request word (append, insert at position, remove at position, read
// at position) yields exactly one response word carrying the value read (zero
// unless a successful read), a status (ok, position out of range, store full) and
// the element count after the operation. A request is captured in a stage
// register and executed once the output register is free or being emptied: every
// cell shifts up, shifts down, loads or holds in parallel from a compare of its
// index with the position, and the response lands in an output register. One
// request is taken per cycle when the response side keeps up. Each response passes
// through the stage register and then the output register. Failed requests leave
// the contents untouched.
`default_nettype none

module indexed_sequence_store_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire iss_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output iss_pkg::rsp_t      rsp
);

	localparam int Depth = iss_pkg::Depth;
	localparam int CntW  = iss_pkg::CntW;
	localparam int IdxW  = iss_pkg::IdxW;
	localparam int DataW = iss_pkg::DataW;
	localparam logic [CntW-1:0] DepthC = CntW'(Depth);

	iss_pkg::req_t                req_s1;
	logic                         valid_s1;
	logic signed [DataW-1:0]      cell_q [Depth];
	logic [CntW-1:0]              count_q;
	iss_pkg::rsp_t                rsp_q;
	logic                         rsp_valid_q;

	logic                         advance;
	logic                         full;
	logic                         ok;
	iss_pkg::status_t             status;
	logic [CntW-1:0]              count_nxt;
	logic signed [DataW-1:0]      rd_value;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign full      = (count_q >= DepthC);

	always_comb begin
		status = iss_pkg::ST_OK;
		unique case (req_s1.mode)
			iss_pkg::MODE_APPEND: begin
				if (full) status = iss_pkg::ST_FULL;
			end
			iss_pkg::MODE_INSERT: begin
				if (req_s1.position > count_q) status = iss_pkg::ST_RANGE;
				else if (full) status = iss_pkg::ST_FULL;
			end
			iss_pkg::MODE_REMOVE,
			iss_pkg::MODE_READ: begin
				if (req_s1.position >= count_q) status = iss_pkg::ST_RANGE;
			end
			default: status = iss_pkg::ST_OK;
		endcase
	end

	assign ok = (status == iss_pkg::ST_OK);

	always_comb begin
		count_nxt = count_q;
		if (ok) begin
			unique case (req_s1.mode)
				iss_pkg::MODE_APPEND,
				iss_pkg::MODE_INSERT: count_nxt = count_q + CntW'(1);
				iss_pkg::MODE_REMOVE: count_nxt = count_q - CntW'(1);
				iss_pkg::MODE_READ:   count_nxt = count_q;
				default:              count_nxt = count_q;
			endcase
		end
	end

	// position is below count_q <= Depth on a good read, so the low bits index the row
	assign rd_value = (ok && req_s1.mode == iss_pkg::MODE_READ)
		? cell_q[req_s1.position[IdxW-1:0]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (req_ready) valid_s1 <= req_valid;
			if (advance) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_nxt;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_s1 <= req;
		if (advance) begin
			rsp_q.read_value <= rd_value;
			rsp_q.status     <= status;
			rsp_q.count      <= count_nxt;
		end
	end

	// each cell decides from its own index: load, take from below, take from above, or hold
	for (genvar i = 0; i < Depth; i++) begin : g_cell
		localparam logic [CntW-1:0] Idx = CntW'(i);
		always_ff @(posedge clk) begin
			if (advance && ok) begin
				unique case (req_s1.mode)
					iss_pkg::MODE_APPEND: begin
						if (count_q == Idx) cell_q[i] <= req_s1.value;
					end
					iss_pkg::MODE_INSERT: begin
						if (req_s1.position == Idx) cell_q[i] <= req_s1.value;
						else if (req_s1.position < Idx) cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
					end
					iss_pkg::MODE_REMOVE: begin
						if (req_s1.position <= Idx && i + 1 < Depth)
							cell_q[i] <= cell_q[(i + 1 < Depth) ? i + 1 : i];
					end
					iss_pkg::MODE_READ: begin
						cell_q[i] <= cell_q[i];
					end
					default: cell_q[i] <= cell_q[i];
				endcase
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthC)
		else $error("element count above depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == iss_pkg::ST_FULL |-> rsp_q.count == DepthC)
		else $error("full status without a full store");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.read_value != '0 |-> rsp_q.status == iss_pkg::ST_OK)
		else $error("nonzero read value on a failed request");

	a_advance_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("executed request produced no response");

	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !ok |=> count_q == $past(count_q))
		else $error("failed request changed the count");

endmodule

`default_nettype wire

// ===== tb/sv/seq_store_check_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the indexed sequence store testbench: shadow list plus expected responses.
// Depends on iss_pkg for the request and response word layouts and codes.
package seq_store_check_pkg;

	import iss_pkg::*;

	class seq_scoreboard;
		logic signed [DataW-1:0] cells [Depth];
		int                      held;
		rsp_t                    pending [$];
		int unsigned             errors;

		function new();
			held   = 0;
			errors = 0;
		endfunction

		// Apply one accepted request to the shadow list and queue its response.
		function void note_request(req_t r);
			rsp_t e;
			int   p;
			e          = '0;
			e.status   = ST_OK;
			p          = int'(r.position);
			case (r.mode)
				MODE_APPEND: begin
					if (held >= Depth) begin
						e.status = ST_FULL;
					end else begin
						cells[held] = r.value;
						held++;
					end
				end
				MODE_INSERT: begin
					// range check wins over the full check
					if (p > held) begin
						e.status = ST_RANGE;
					end else if (held >= Depth) begin
						e.status = ST_FULL;
					end else begin
						for (int i = held; i > p; i--)
							cells[i] = cells[i-1];
						cells[p] = r.value;
						held++;
					end
				end
				MODE_REMOVE: begin
					if (p >= held) begin
						e.status = ST_RANGE;
					end else begin
						for (int i = p; i + 1 < held; i++)
							cells[i] = cells[i+1];
						held--;
					end
				end
				default: begin
					if (p >= held)
						e.status = ST_RANGE;
					else
						e.read_value = cells[p];
				end
			endcase
			e.count = CntW'(held);
			pending.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("response word with no request outstanding: %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.read_value !== e.read_value) begin
				$error("read_value: expected %0d, got %0d", e.read_value, got.read_value);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.count !== e.count) begin
				$error("count: expected %0d, got %0d", e.count, got.count);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

endpackage

// ===== tb/sv/indexed_sequence_store_top_test.sv =====
`timescale 1ns / 100ps
// Top of the indexed sequence store testbench: clock, reset, request and response drivers.
// Depends on iss_pkg, seq_store_check_pkg and the indexed_sequence_store_top block.
module indexed_sequence_store_top_test;

	import iss_pkg::*;
	import seq_store_check_pkg::*;

	localparam int TotalWords = 1950;
	localparam int QuietTail  = 200;
	localparam int StallLimit = 1000;

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	bit    calm      = 1'b0;
	int    idle_cycles = 0;

	seq_scoreboard sb;
	req_t          directed [$];

	indexed_sequence_store_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic req_t make_req(mode_t m, int p, logic signed [DataW-1:0] v);
		req_t r;
		r.mode     = m;
		r.position = CntW'(p);
		r.value    = v;
		return r;
	endfunction

	function automatic logic signed [DataW-1:0] pick_value();
		case ($urandom_range(15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// Mostly in-range positions against the current list length, some out of range.
	function automatic req_t next_random(bit grow);
		int    n;
		int    roll;
		int    p;
		mode_t m;
		bit    wild;
		n    = sb.held;
		roll = $urandom_range(99);
		if (grow)
			m = (roll < 35) ? MODE_APPEND : (roll < 60) ? MODE_INSERT :
			    (roll < 75) ? MODE_REMOVE : MODE_READ;
		else
			m = (roll < 15) ? MODE_APPEND : (roll < 30) ? MODE_INSERT :
			    (roll < 70) ? MODE_REMOVE : MODE_READ;
		wild = ($urandom_range(9) == 0);
		case (m)
			MODE_APPEND: p = $urandom_range(31);
			MODE_INSERT: p = wild ? ((n >= 31) ? 31 : $urandom_range(31, n + 1))
			                      : $urandom_range(n);
			default:     p = (wild || n == 0) ? $urandom_range(31, n) : $urandom_range(n - 1);
		endcase
		return make_req(m, p, pick_value());
	endfunction

	task automatic build_directed();
		// empty list: everything positional is out of range
		directed.push_back(make_req(MODE_READ,   0,  32'sd0));
		directed.push_back(make_req(MODE_REMOVE, 0,  32'sd0));
		directed.push_back(make_req(MODE_INSERT, 1,  32'sd5));
		// one element, then remove it to empty the list
		directed.push_back(make_req(MODE_INSERT, 0,  32'sh8000_0000));
		directed.push_back(make_req(MODE_READ,   0,  32'sd0));
		directed.push_back(make_req(MODE_REMOVE, 0,  32'sd0));
		directed.push_back(make_req(MODE_APPEND, 31, 32'sh7fff_ffff));
		directed.push_back(make_req(MODE_INSERT, 0,  32'sh8000_0000));
		directed.push_back(make_req(MODE_INSERT, 1,  32'shaaaa_aaaa));
		directed.push_back(make_req(MODE_INSERT, 3,  32'sh5555_5555));
		directed.push_back(make_req(MODE_READ,   3,  32'sd0));
		directed.push_back(make_req(MODE_READ,   4,  32'sd0));
		directed.push_back(make_req(MODE_REMOVE, 31, 32'sd0));
		directed.push_back(make_req(MODE_INSERT, 31, 32'sd1));
		// fill to capacity
		for (int i = 0; i < Depth - 4; i++)
			directed.push_back(make_req(MODE_APPEND, 0, pick_value()));
		directed.push_back(make_req(MODE_APPEND, 0,  32'sd7));
		directed.push_back(make_req(MODE_INSERT, 5,  32'sd8));
		directed.push_back(make_req(MODE_INSERT, 17, 32'sd9));
		directed.push_back(make_req(MODE_INSERT, 16, 32'sd10));
		directed.push_back(make_req(MODE_READ,   15, 32'sd0));
		directed.push_back(make_req(MODE_REMOVE, 15, 32'sd0));
		directed.push_back(make_req(MODE_READ,   0,  32'sd0));
	endtask

	task automatic drive_requests();
		req_t r;
		int   gap;
		bit   grow;
		grow = 1'b1;
		for (int k = 0; k < TotalWords; k++) begin
			calm = ((k % 400) < 80) || (k >= TotalWords - QuietTail);
			if (k % 150 == 0)
				grow = ~grow;
			if (k < directed.size())
				r = directed[k];
			else
				r = next_random(grow);
			gap = (!calm && $urandom_range(3) == 0) ? $urandom_range(12, 1) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req       <= r;
			req_valid <= 1'b1;
			do @(posedge clk); while (!req_ready);
			sb.note_request(r);
		end
		req_valid <= 1'b0;
	endtask

	task automatic drain_responses();
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!calm && $urandom_range(5) == 0) begin
				stall_left = $urandom_range(12, 1) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	endtask

	// End the run when neither side moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("indexed_sequence_store_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		build_directed();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drain_responses();
		join_none
		drive_requests();
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("indexed_sequence_store_top verification clean");
		end else begin
			$display("indexed_sequence_store_top verification failed");
		end
		$finish;
	end

endmodule
